### design/cbu_pkg.sv
// Package for the conditional branch unit: operation codes, condition codes,
// cycle costs, the condition evaluation function and the stage structs.
// No dependencies.
package cbu_pkg;

   // Operation codes on req_op.
   localparam logic [1:0] OP_BRANCH = 2'd0;
   localparam logic [1:0] OP_DBCC   = 2'd1;
   localparam logic [1:0] OP_SCC    = 2'd2;

   // Condition codes (opcode bits 11..8).
   localparam logic [3:0] CC_T  = 4'd0;
   localparam logic [3:0] CC_F  = 4'd1;
   localparam logic [3:0] CC_HI = 4'd2;
   localparam logic [3:0] CC_LS = 4'd3;
   localparam logic [3:0] CC_CC = 4'd4;
   localparam logic [3:0] CC_CS = 4'd5;
   localparam logic [3:0] CC_NE = 4'd6;
   localparam logic [3:0] CC_EQ = 4'd7;
   localparam logic [3:0] CC_VC = 4'd8;
   localparam logic [3:0] CC_VS = 4'd9;
   localparam logic [3:0] CC_PL = 4'd10;
   localparam logic [3:0] CC_MI = 4'd11;
   localparam logic [3:0] CC_GE = 4'd12;
   localparam logic [3:0] CC_LT = 4'd13;
   localparam logic [3:0] CC_GT = 4'd14;

   // In the branch group, the F code encodes BSR.
   localparam logic [3:0] CC_BSR = CC_F;

   // Scc mode field value for a data register destination.
   localparam logic [2:0] MODE_DATA_REG = 3'd0;

   // Counter value at which DBcc expires.
   localparam logic [15:0] COUNT_EXPIRED = 16'hFFFF;

   // Scc byte values.
   localparam logic [7:0] BYTE_TRUE  = 8'hFF;
   localparam logic [7:0] BYTE_FALSE = 8'h00;

   // Cycle costs charged to the emulated CPU.
   localparam logic [4:0] COST_NONE          = 5'd0;
   localparam logic [4:0] COST_BSR           = 5'd18;
   localparam logic [4:0] COST_BCC_TAKEN     = 5'd10;
   localparam logic [4:0] COST_BCC_WORD_NT   = 5'd12;
   localparam logic [4:0] COST_BCC_BYTE_NT   = 5'd8;
   localparam logic [4:0] COST_DBCC_TRUE     = 5'd12;
   localparam logic [4:0] COST_DBCC_LOOP     = 5'd10;
   localparam logic [4:0] COST_DBCC_EXPIRED  = 5'd14;
   localparam logic [4:0] COST_SCC_REG_TRUE  = 5'd6;
   localparam logic [4:0] COST_SCC_REG_FALSE = 5'd4;
   localparam logic [4:0] COST_SCC_MEM       = 5'd8;

   // Evaluate one condition code against the flags N, Z, V, C.
   function automatic logic cond_eval(input logic [3:0] code, input logic [3:0] nzvc);
      logic n;
      logic z;
      logic v;
      logic c;
      logic r;
      n = nzvc[3];
      z = nzvc[2];
      v = nzvc[1];
      c = nzvc[0];
      case (code)
         CC_T:    r = 1'b1;
         CC_F:    r = 1'b0;
         CC_HI:   r = !c && !z;
         CC_LS:   r = c || z;
         CC_CC:   r = !c;
         CC_CS:   r = c;
         CC_NE:   r = !z;
         CC_EQ:   r = z;
         CC_VC:   r = !v;
         CC_VS:   r = v;
         CC_PL:   r = !n;
         CC_MI:   r = n;
         CC_GE:   r = (n == v);
         CC_LT:   r = (n != v);
         CC_GT:   r = (n == v) && !z;
         default: r = z || (n != v);
      endcase
      return r;
   endfunction

   // Decoded request, held after the first stage.
   typedef struct packed {
      logic [1:0]  op;
      logic        cond;
      logic        is_bsr;
      logic        is_word;
      logic        to_reg;
      logic [31:0] disp;
      logic [31:0] pc;
      logic [15:0] cnt_dec;
      logic        cnt_expired;
   } dec_type;

   // Request with its addresses computed, held after the second stage.
   typedef struct packed {
      logic [1:0]  op;
      logic        cond;
      logic        is_bsr;
      logic        is_word;
      logic        to_reg;
      logic [31:0] pc;
      logic [31:0] pc_plus2;
      logic [31:0] target;
      logic [15:0] cnt_dec;
      logic        cnt_expired;
   } addr_type;

   // Finished result, held in the output register.
   typedef struct packed {
      logic        condition_true;
      logic        branch_taken;
      logic [31:0] next_pc;
      logic        push_return;
      logic [31:0] return_address;
      logic        counter_write;
      logic [15:0] counter_value;
      logic [7:0]  set_byte;
      logic        byte_to_register;
      logic        odd_target_fault;
      logic [31:0] fault_frame_pc;
      logic [4:0]  cycle_cost;
   } rsp_type;

endpackage

### design/cbu_decode.sv
// First-stage decode of the conditional branch unit: condition evaluation,
// displacement sign extension and counter decrement. Uses cbu_pkg.
module cbu_decode (
   input  logic [1:0]       op,
   input  logic [15:0]      opcode_word,
   input  logic [15:0]      extension_word,
   input  logic [31:0]      pc_after_opcode,
   input  logic [3:0]       flags_nzvc,
   input  logic [15:0]      counter_low,
   output cbu_pkg::dec_type dec
);

   logic [3:0]  code;
   logic        is_word;
   logic [31:0] disp_word;
   logic [31:0] disp_byte;

   // Displacement forms: the extension word, or the low opcode byte.
   assign code      = opcode_word[11:8];
   assign is_word   = (opcode_word[7:0] == 8'h00);
   assign disp_word = {{16{extension_word[15]}}, extension_word};
   assign disp_byte = {{24{opcode_word[7]}}, opcode_word[7:0]};

   // DBcc always uses the word displacement; Bcc uses the byte one unless it is zero.
   always_comb begin
      dec.op          = op;
      dec.cond        = cbu_pkg::cond_eval(code, flags_nzvc);
      dec.is_bsr      = (code == cbu_pkg::CC_BSR);
      dec.is_word     = is_word;
      dec.to_reg      = (opcode_word[5:3] == cbu_pkg::MODE_DATA_REG);
      dec.disp        = (op == cbu_pkg::OP_BRANCH && !is_word) ? disp_byte : disp_word;
      dec.pc          = pc_after_opcode;
      dec.cnt_dec     = counter_low - 16'd1;
      dec.cnt_expired = (counter_low == 16'd0);
   end

endmodule

### design/cbu_resolve.sv
// Final stage of the conditional branch unit: picks next PC, fault, counter
// write, Scc byte and cycle cost from the computed addresses. Uses cbu_pkg.
module cbu_resolve (
   input  cbu_pkg::addr_type ad,
   output cbu_pkg::rsp_type  rsp
);

   logic [31:0] after;

   // Bcc resumes past the extension word only when it had one.
   assign after = ad.is_word ? ad.pc_plus2 : ad.pc;

   always_comb begin
      rsp = '0;
      rsp.next_pc = ad.pc;
      case (ad.op)
         cbu_pkg::OP_BRANCH: begin
            rsp.condition_true = ad.cond;
            if (ad.is_bsr) begin
               // BSR always pushes; an odd target faults instead of branching.
               rsp.push_return    = 1'b1;
               rsp.return_address = after;
               rsp.cycle_cost     = cbu_pkg::COST_BSR;
               rsp.next_pc        = ad.target;
               if (ad.target[0]) begin
                  rsp.odd_target_fault = 1'b1;
                  rsp.fault_frame_pc   = ad.target;
               end else begin
                  rsp.branch_taken = 1'b1;
               end
            end else if (ad.cond) begin
               rsp.branch_taken = 1'b1;
               rsp.next_pc      = ad.target;
               rsp.cycle_cost   = cbu_pkg::COST_BCC_TAKEN;
            end else begin
               rsp.next_pc    = after;
               rsp.cycle_cost = ad.is_word ? cbu_pkg::COST_BCC_WORD_NT
                                           : cbu_pkg::COST_BCC_BYTE_NT;
            end
         end
         cbu_pkg::OP_DBCC: begin
            rsp.condition_true = ad.cond;
            rsp.next_pc        = ad.pc_plus2;
            if (ad.cond) begin
               rsp.cycle_cost = cbu_pkg::COST_DBCC_TRUE;
            end else if (!ad.cnt_expired) begin
               // Loop branch; an odd target faults and keeps the counter.
               rsp.cycle_cost = cbu_pkg::COST_DBCC_LOOP;
               rsp.next_pc    = ad.target;
               if (ad.target[0]) begin
                  rsp.odd_target_fault = 1'b1;
                  rsp.fault_frame_pc   = ad.pc_plus2;
               end else begin
                  rsp.branch_taken  = 1'b1;
                  rsp.counter_write = 1'b1;
                  rsp.counter_value = ad.cnt_dec;
               end
            end else begin
               rsp.counter_write = 1'b1;
               rsp.counter_value = ad.cnt_dec;
               rsp.cycle_cost    = cbu_pkg::COST_DBCC_EXPIRED;
            end
         end
         cbu_pkg::OP_SCC: begin
            rsp.condition_true   = ad.cond;
            rsp.set_byte         = ad.cond ? cbu_pkg::BYTE_TRUE : cbu_pkg::BYTE_FALSE;
            rsp.byte_to_register = ad.to_reg;
            if (ad.to_reg) begin
               rsp.cycle_cost = ad.cond ? cbu_pkg::COST_SCC_REG_TRUE
                                        : cbu_pkg::COST_SCC_REG_FALSE;
            end else begin
               rsp.cycle_cost = cbu_pkg::COST_SCC_MEM;
            end
         end
         default: begin
            rsp.next_pc    = ad.pc;
            rsp.cycle_cost = cbu_pkg::COST_NONE;
         end
      endcase
   end

endmodule

### design/conditional_branch_unit.sv
// Conditional branch unit: evaluates the condition codes and executes one
// Bcc/BRA/BSR, DBcc or Scc request per cycle while req_stall is low. It is a
// three-stage pipeline (decode, address add, result select into the output
// register); a request passes through dec_ff, addr_ff and rsp_ff in turn. Each
// stage holds its request while the stage after it is full and stalled;
// req_stall rises only when all three stages are full and rsp_stall is high.
// The unit keeps no state between requests.
// Depends on cbu_pkg, cbu_decode and cbu_resolve.
module conditional_branch_unit (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_opcode_word,
   input  logic [15:0] req_extension_word,
   input  logic [31:0] req_pc_after_opcode,
   input  logic [3:0]  req_flags_nzvc,
   input  logic [15:0] req_counter_low,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_condition_true,
   output logic        rsp_branch_taken,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_push_return,
   output logic [31:0] rsp_return_address,
   output logic        rsp_counter_write,
   output logic [15:0] rsp_counter_value,
   output logic [7:0]  rsp_set_byte,
   output logic        rsp_byte_to_register,
   output logic        rsp_odd_target_fault,
   output logic [31:0] rsp_fault_frame_pc,
   output logic [4:0]  rsp_cycle_cost
);

   cbu_pkg::dec_type  dec_in;
   cbu_pkg::dec_type  dec_ff;
   cbu_pkg::addr_type addr_in;
   cbu_pkg::addr_type addr_ff;
   cbu_pkg::rsp_type  rsp_in;
   cbu_pkg::rsp_type  rsp_ff;

   logic dec_valid_ff;
   logic addr_valid_ff;
   logic rsp_valid_ff;

   logic rsp_ready;
   logic addr_ready;
   logic dec_ready;

   // A stage may load when it is empty or its content moves on this cycle.
   assign rsp_ready  = !rsp_valid_ff || !rsp_stall;
   assign addr_ready = !addr_valid_ff || rsp_ready;
   assign dec_ready  = !dec_valid_ff || addr_ready;
   assign req_stall  = !dec_ready;

   // Stage one: decode.
   cbu_decode u_decode (
      .op              (req_op),
      .opcode_word     (req_opcode_word),
      .extension_word  (req_extension_word),
      .pc_after_opcode (req_pc_after_opcode),
      .flags_nzvc      (req_flags_nzvc),
      .counter_low     (req_counter_low),
      .dec             (dec_in)
   );

   // Stage two: target and fall-through address adds.
   always_comb begin
      addr_in.op          = dec_ff.op;
      addr_in.cond        = dec_ff.cond;
      addr_in.is_bsr      = dec_ff.is_bsr;
      addr_in.is_word     = dec_ff.is_word;
      addr_in.to_reg      = dec_ff.to_reg;
      addr_in.pc          = dec_ff.pc;
      addr_in.pc_plus2    = dec_ff.pc + 32'd2;
      addr_in.target      = dec_ff.pc + dec_ff.disp;
      addr_in.cnt_dec     = dec_ff.cnt_dec;
      addr_in.cnt_expired = dec_ff.cnt_expired;
   end

   // Stage three: result selection.
   cbu_resolve u_resolve (
      .ad  (addr_ff),
      .rsp (rsp_in)
   );

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff  <= 1'b0;
         addr_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (dec_ready) begin
            dec_valid_ff <= req_valid;
         end
         if (addr_ready) begin
            addr_valid_ff <= dec_valid_ff;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= addr_valid_ff;
         end
      end
   end

   // Payload registers load with their stage.
   always_ff @(posedge clock) begin
      if (dec_ready) begin
         dec_ff <= dec_in;
      end
      if (addr_ready) begin
         addr_ff <= addr_in;
      end
      if (rsp_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   // Output ports.
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_condition_true   = rsp_ff.condition_true;
   assign rsp_branch_taken     = rsp_ff.branch_taken;
   assign rsp_next_pc          = rsp_ff.next_pc;
   assign rsp_push_return      = rsp_ff.push_return;
   assign rsp_return_address   = rsp_ff.return_address;
   assign rsp_counter_write    = rsp_ff.counter_write;
   assign rsp_counter_value    = rsp_ff.counter_value;
   assign rsp_set_byte         = rsp_ff.set_byte;
   assign rsp_byte_to_register = rsp_ff.byte_to_register;
   assign rsp_odd_target_fault = rsp_ff.odd_target_fault;
   assign rsp_fault_frame_pc   = rsp_ff.fault_frame_pc;
   assign rsp_cycle_cost       = rsp_ff.cycle_cost;

endmodule
